### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the translator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### hw/rtl/wst_pkg.sv
// Shared types, constants and event codes of the wheel to swipe translator.
`timescale 1ns / 1ps

package wst_pkg;

   localparam int SCREEN_MAX_X = 1919;
   localparam int FINGER_GAP   = 200;
   localparam int POS_HI_RAW   = SCREEN_MAX_X - FINGER_GAP;
   localparam int POS_HI       = (POS_HI_RAW < 0) ? 0 : POS_HI_RAW;
   localparam int POS_HOME     = 960;
   localparam int POS_MAXV     = (POS_HI > POS_HOME) ? POS_HI : POS_HOME;
   localparam int POS_W        = $clog2(POS_MAXV + 1);

   localparam int TRACK_BASE = 100;
   localparam int Y_BASE     = 500;
   localparam int Y_STEP     = 100;

   localparam logic [15:0] IDLE_TIMEOUT_RESET  = 16'd500;
   localparam logic [7:0]  VERTICAL_GAIN_RESET = 8'h01;
   localparam logic [7:0]  PIXEL_GAIN_RESET    = 8'hFF;

   localparam logic [1:0] CSR_IDLE_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_VERTICAL_GAIN = 2'd1;
   localparam logic [1:0] CSR_PIXEL_GAIN    = 2'd2;

   localparam logic [4:0] EV_SYN = 5'd0;
   localparam logic [4:0] EV_KEY = 5'd1;
   localparam logic [4:0] EV_REL = 5'd2;
   localparam logic [4:0] EV_ABS = 5'd3;

   localparam logic [9:0] CODE_HSCROLL       = 10'd6;
   localparam logic [9:0] CODE_VSCROLL       = 10'd8;
   localparam logic [9:0] CODE_VSCROLL_FINE  = 10'd11;
   localparam logic [9:0] CODE_HSCROLL_FINE  = 10'd12;
   localparam logic [9:0] CODE_TOUCH         = 10'd330;
   localparam logic [9:0] BTN_TOOL_DTAP      = 10'd333;
   localparam logic [9:0] CODE_SLOT          = 10'd47;
   localparam logic [9:0] ABS_MT_TRACK       = 10'd57;
   localparam logic [9:0] ABS_MT_POS_X       = 10'd53;
   localparam logic [9:0] ABS_MT_POS_Y       = 10'd54;
   localparam logic [9:0] CODE_SYNC          = 10'd0;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_MOVE,
      CMD_LIFT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         touch_down;
      logic [4:0]   ev_type;
      logic [9:0]   ev_code;
      logic [31:0]  value;
   } cmd_type;

endpackage

### hw/rtl/wheel_to_swipe_translator_top.sv
// Top level of the wheel to swipe translator.
// The request channel takes one word per cycle while req_stall is low: an
// input event (op low) or a millisecond tick (op high). A high-resolution
// horizontal wheel event moves the two virtual fingers and yields seven touch
// events, or thirteen when the fingers first go down. A tick at the idle
// timeout lifts the fingers with seven touch events. Plain horizontal wheel
// events are dropped; other events go to the mouse device as a single word.
// Classification, the gain multiplier and the touch state sit in the front
// end, which takes a word in every cycle while its four-entry command queue
// has room. The back end emits one result word per cycle from the queue head
// while the receiver does not stall, so the sustained rate is set by the
// result port. An accepted request is written into the queue, and its words
// are then registered from the queue head into the output register.
// While the receiver stalls, the output register holds its word and the queue
// fills; once it is full, req_stall rises.
// A synchronous reset empties the queue and the output register, puts the
// fingers up at the home position and restores the register defaults.
`timescale 1ns / 1ps

module wheel_to_swipe_translator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [4:0]  req_ev_type,
   input  logic [9:0]  req_ev_code,
   input  logic [31:0] req_ev_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_dest,
   output logic [4:0]  rsp_out_type,
   output logic [9:0]  rsp_out_code,
   output logic [31:0] rsp_out_value,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   logic             push, pop, not_empty, full;
   wst_pkg::cmd_type push_cmd, head_cmd;

   assign req_stall = full;

   wst_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_ev_type      (req_ev_type),
      .req_ev_code      (req_ev_code),
      .req_ev_value     (req_ev_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   wst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (not_empty),
      .full      (full)
   );

   wst_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .not_empty     (not_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_dest      (rsp_dest),
      .rsp_out_type  (rsp_out_type),
      .rsp_out_code  (rsp_out_code),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule

### hw/rtl/wst_front.sv
// Front end: accepts words, holds the registers and touch state, and queues commands.
`timescale 1ns / 1ps

module wst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_op,
   input  logic [4:0]        req_ev_type,
   input  logic [9:0]        req_ev_code,
   input  logic [31:0]       req_ev_value,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_write_data,
   output logic              push,
   output wst_pkg::cmd_type  push_cmd
);

   logic [15:0]                timeout_ff;
   logic [7:0]                 vgain_ff;
   logic [7:0]                 pgain_ff;
   logic                       touching_ff, touching_in;
   logic [wst_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]                idle_ff, idle_in;

   logic                       accept;
   logic                       is_rel, is_hires, is_hwheel, is_vert;
   logic signed [7:0]          gain_sel;
   logic signed [39:0]         prod;
   logic signed [40:0]         sum;
   logic [wst_pkg::POS_W-1:0]  pos_clamped;
   logic [15:0]                idle_inc;
   logic                       lift;

   assign accept    = req_valid && !req_stall;
   assign is_rel    = (req_ev_type == wst_pkg::EV_REL);
   assign is_hires  = is_rel && (req_ev_code == wst_pkg::CODE_HSCROLL_FINE);
   assign is_hwheel = is_rel && (req_ev_code == wst_pkg::CODE_HSCROLL);
   assign is_vert   = is_rel && ((req_ev_code == wst_pkg::CODE_VSCROLL) ||
                                 (req_ev_code == wst_pkg::CODE_VSCROLL_FINE));

   assign gain_sel = is_hires ? $signed(pgain_ff) : $signed(vgain_ff);
   assign prod     = $signed(req_ev_value) * gain_sel;
   assign sum      = $signed({{(41 - wst_pkg::POS_W){1'b0}}, pos_ff}) + $signed({prod[39], prod});

   always_comb begin
      if (sum[40]) begin
         pos_clamped = '0;
      end else if (sum > $signed(41'(wst_pkg::POS_HI))) begin
         pos_clamped = wst_pkg::POS_W'(wst_pkg::POS_HI);
      end else begin
         pos_clamped = sum[wst_pkg::POS_W-1:0];
      end
   end

   assign idle_inc = (idle_ff != 16'hFFFF) ? idle_ff + 16'd1 : idle_ff;
   assign lift     = (idle_inc >= timeout_ff);

   always_comb begin
      touching_in         = touching_ff;
      pos_in              = pos_ff;
      idle_in             = idle_ff;
      push                = 1'b0;
      push_cmd.kind       = wst_pkg::CMD_PASS;
      push_cmd.touch_down = !touching_ff;
      push_cmd.ev_type    = req_ev_type;
      push_cmd.ev_code    = req_ev_code;
      push_cmd.value      = req_ev_value;
      if (accept) begin
         if (req_op) begin
            if (touching_ff) begin
               if (lift) begin
                  push          = 1'b1;
                  push_cmd.kind = wst_pkg::CMD_LIFT;
                  touching_in   = 1'b0;
                  pos_in        = wst_pkg::POS_W'(wst_pkg::POS_HOME);
                  idle_in       = '0;
               end else begin
                  idle_in = idle_inc;
               end
            end
         end else if (is_hires) begin
            push           = 1'b1;
            push_cmd.kind  = wst_pkg::CMD_MOVE;
            push_cmd.value = {{(32 - wst_pkg::POS_W){1'b0}}, pos_clamped};
            pos_in         = pos_clamped;
            idle_in        = '0;
            touching_in    = 1'b1;
         end else if (!is_hwheel) begin
            push = 1'b1;
            if (is_vert) begin
               push_cmd.value = prod[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= wst_pkg::IDLE_TIMEOUT_RESET;
         vgain_ff    <= wst_pkg::VERTICAL_GAIN_RESET;
         pgain_ff    <= wst_pkg::PIXEL_GAIN_RESET;
         touching_ff <= 1'b0;
         pos_ff      <= wst_pkg::POS_W'(wst_pkg::POS_HOME);
         idle_ff     <= '0;
      end else begin
         touching_ff <= touching_in;
         pos_ff      <= pos_in;
         idle_ff     <= idle_in;
         if (csr_write_enable) begin
            case (csr_index)
               wst_pkg::CSR_IDLE_TIMEOUT:  timeout_ff <= csr_write_data;
               wst_pkg::CSR_VERTICAL_GAIN: vgain_ff   <= csr_write_data[7:0];
               wst_pkg::CSR_PIXEL_GAIN:    pgain_ff   <= csr_write_data[7:0];
               default: ;
            endcase
         end
      end
   end

endmodule

### hw/rtl/wst_queue.sv
// Short command queue between the front end and the event sequencer.
`timescale 1ns / 1ps

module wst_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wst_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output wst_pkg::cmd_type  head_cmd,
   output logic              not_empty,
   output logic              full
);

   wst_pkg::cmd_type               mem [wst_pkg::Q_DEPTH];
   logic [wst_pkg::Q_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [wst_pkg::Q_PTR_W:0]      count_ff, count_in;

   assign head_cmd  = mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (wst_pkg::Q_PTR_W + 1)'(wst_pkg::Q_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

### hw/rtl/wst_back.sv
// Back end: steps through the events of each queued command into the output register.
`timescale 1ns / 1ps

module wst_back (
   input  logic              clock,
   input  logic              reset,
   input  wst_pkg::cmd_type  head_cmd,
   input  logic              not_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_dest,
   output logic [4:0]        rsp_out_type,
   output logic [9:0]        rsp_out_code,
   output logic [31:0]       rsp_out_value,
   output logic              rsp_last
);

   logic [3:0]  step_ff, step_in;
   logic [3:0]  idx;
   logic        advance;
   logic        dest;
   logic [4:0]  ev_type;
   logic [9:0]  ev_code;
   logic [31:0] ev_value;
   logic        is_last;
   logic        rsp_valid_ff;
   logic        dest_ff, last_ff;
   logic [4:0]  type_ff;
   logic [9:0]  code_ff;
   logic [31:0] value_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign idx     = (head_cmd.kind == wst_pkg::CMD_MOVE && !head_cmd.touch_down) ?
                    step_ff + 4'd6 : step_ff;

   always_comb begin
      dest     = 1'b0;
      ev_type  = wst_pkg::EV_ABS;
      ev_code  = wst_pkg::CODE_SLOT;
      ev_value = '0;
      is_last  = 1'b0;
      case (head_cmd.kind)
         wst_pkg::CMD_PASS: begin
            dest     = 1'b1;
            ev_type  = head_cmd.ev_type;
            ev_code  = head_cmd.ev_code;
            ev_value = head_cmd.value;
            is_last  = 1'b1;
         end
         wst_pkg::CMD_MOVE: begin
            case (idx)
               4'd0: begin
                  ev_type  = wst_pkg::EV_KEY;
                  ev_code  = wst_pkg::CODE_TOUCH;
                  ev_value = 32'd1;
               end
               4'd1: begin
                  ev_type  = wst_pkg::EV_KEY;
                  ev_code  = wst_pkg::BTN_TOOL_DTAP;
                  ev_value = 32'd1;
               end
               4'd2: ev_value = 32'd0;
               4'd3: begin
                  ev_code  = wst_pkg::ABS_MT_TRACK;
                  ev_value = 32'(wst_pkg::TRACK_BASE);
               end
               4'd4: ev_value = 32'd1;
               4'd5: begin
                  ev_code  = wst_pkg::ABS_MT_TRACK;
                  ev_value = 32'(wst_pkg::TRACK_BASE + 1);
               end
               4'd6: ev_value = 32'd0;
               4'd7: begin
                  ev_code  = wst_pkg::ABS_MT_POS_X;
                  ev_value = head_cmd.value;
               end
               4'd8: begin
                  ev_code  = wst_pkg::ABS_MT_POS_Y;
                  ev_value = 32'(wst_pkg::Y_BASE);
               end
               4'd9: ev_value = 32'd1;
               4'd10: begin
                  ev_code  = wst_pkg::ABS_MT_POS_X;
                  ev_value = head_cmd.value + 32'(wst_pkg::FINGER_GAP);
               end
               4'd11: begin
                  ev_code  = wst_pkg::ABS_MT_POS_Y;
                  ev_value = 32'(wst_pkg::Y_BASE + wst_pkg::Y_STEP);
               end
               default: begin
                  ev_type = wst_pkg::EV_SYN;
                  ev_code = wst_pkg::CODE_SYNC;
                  is_last = 1'b1;
               end
            endcase
         end
         default: begin
            case (idx)
               4'd0: ev_value = 32'd0;
               4'd1: begin
                  ev_code  = wst_pkg::ABS_MT_TRACK;
                  ev_value = 32'hFFFF_FFFF;
               end
               4'd2: ev_value = 32'd1;
               4'd3: begin
                  ev_code  = wst_pkg::ABS_MT_TRACK;
                  ev_value = 32'hFFFF_FFFF;
               end
               4'd4: begin
                  ev_type = wst_pkg::EV_KEY;
                  ev_code = wst_pkg::CODE_TOUCH;
               end
               4'd5: begin
                  ev_type = wst_pkg::EV_KEY;
                  ev_code = wst_pkg::BTN_TOOL_DTAP;
               end
               default: begin
                  ev_type = wst_pkg::EV_SYN;
                  ev_code = wst_pkg::CODE_SYNC;
                  is_last = 1'b1;
               end
            endcase
         end
      endcase
   end

   assign pop = advance && not_empty && is_last;

   always_comb begin
      step_in = step_ff;
      if (advance && not_empty) begin
         step_in = is_last ? 4'd0 : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && not_empty) begin
         dest_ff  <= dest;
         type_ff  <= ev_type;
         code_ff  <= ev_code;
         value_ff <= ev_value;
         last_ff  <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         step_ff <= step_in;
         if (advance) begin
            rsp_valid_ff <= not_empty;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dest      = dest_ff;
   assign rsp_out_type  = type_ff;
   assign rsp_out_code  = code_ff;
   assign rsp_out_value = value_ff;
   assign rsp_last      = last_ff;

endmodule

### hw/rtl/wst_checker.sv
// Port-level checks on the translator's result channel, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wst_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_dest,
   input logic [4:0]  rsp_out_type,
   input logic [31:0] rsp_out_value,
   input logic        rsp_last
);

   `ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_NEXT(a_stalled_word_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_value) && $stable(rsp_last))
   `ASSERT_IMPL(a_mouse_word_last, clock, reset, rsp_valid && rsp_dest, rsp_last)
   `ASSERT_IMPL(a_touch_sync_last, clock, reset, rsp_valid && !rsp_dest && (rsp_out_type == wst_pkg::EV_SYN), rsp_last)

endmodule

bind wheel_to_swipe_translator_top wst_checker u_wst_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_dest      (rsp_dest),
   .rsp_out_type  (rsp_out_type),
   .rsp_out_value (rsp_out_value),
   .rsp_last      (rsp_last)
);

### bench/swipe_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the touch and mouse event words of the translator.
`timescale 1ns / 1ps

package swipe_scoreboard_pkg;

   import wst_pkg::*;

   typedef struct {
      logic        dest;
      logic [4:0]  ev_type;
      logic [9:0]  ev_code;
      logic [31:0] value;
      logic        last;
   } emitted_event_type;

   class swipe_scoreboard;

      logic [15:0]        idle_limit;
      logic signed [7:0]  vert_gain;
      logic signed [7:0]  px_gain;
      logic               touching;
      int                 left_x;
      int unsigned        idle_ticks;
      emitted_event_type  pending_events[$];
      int                 mismatches;

      function new();
         idle_limit = IDLE_TIMEOUT_RESET;
         vert_gain  = VERTICAL_GAIN_RESET;
         px_gain    = PIXEL_GAIN_RESET;
         touching   = 1'b0;
         left_x     = POS_HOME;
         idle_ticks = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_IDLE_TIMEOUT: begin
               idle_limit = data;
            end
            CSR_VERTICAL_GAIN: begin
               vert_gain = data[7:0];
            end
            CSR_PIXEL_GAIN: begin
               px_gain = data[7:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void push_event(logic dest, logic [4:0] t, logic [9:0] c, logic [31:0] v);
         emitted_event_type w;
         w.dest    = dest;
         w.ev_type = t;
         w.ev_code = c;
         w.value   = v;
         w.last    = 1'b0;
         pending_events.push_back(w);
      endfunction

      // Works out every word that one accepted request word leads to.
      function void note_request(logic op, logic [4:0] t, logic [9:0] c, logic [31:0] v);
         int          n;
         longint      x;
         logic [31:0] gain_ext;
         logic [31:0] prod;
         n = pending_events.size();
         if (op) begin
            if (touching) begin
               if (idle_ticks < 65535) begin
                  idle_ticks++;
               end
               if (idle_ticks >= idle_limit) begin
                  for (int s = 0; s < 2; s++) begin
                     push_event(1'b0, EV_ABS, CODE_SLOT, 32'(s));
                     push_event(1'b0, EV_ABS, ABS_MT_TRACK, 32'hFFFF_FFFF);
                  end
                  push_event(1'b0, EV_KEY, CODE_TOUCH, 32'd0);
                  push_event(1'b0, EV_KEY, BTN_TOOL_DTAP, 32'd0);
                  push_event(1'b0, EV_SYN, CODE_SYNC, 32'd0);
                  touching   = 1'b0;
                  left_x     = POS_HOME;
                  idle_ticks = 0;
               end
            end
         end else if (t == EV_REL && c == CODE_HSCROLL_FINE) begin
            x = longint'(left_x) + longint'($signed(v)) * longint'(px_gain);
            if (x < 0) begin
               x = 0;
            end
            if (x > POS_HI) begin
               x = POS_HI;
            end
            left_x     = int'(x);
            idle_ticks = 0;
            if (!touching) begin
               push_event(1'b0, EV_KEY, CODE_TOUCH, 32'd1);
               push_event(1'b0, EV_KEY, BTN_TOOL_DTAP, 32'd1);
               for (int s = 0; s < 2; s++) begin
                  push_event(1'b0, EV_ABS, CODE_SLOT, 32'(s));
                  push_event(1'b0, EV_ABS, ABS_MT_TRACK, 32'(TRACK_BASE + s));
               end
            end
            for (int s = 0; s < 2; s++) begin
               push_event(1'b0, EV_ABS, CODE_SLOT, 32'(s));
               push_event(1'b0, EV_ABS, ABS_MT_POS_X, 32'(left_x + (s == 1 ? FINGER_GAP : 0)));
               push_event(1'b0, EV_ABS, ABS_MT_POS_Y, 32'(Y_BASE + s * Y_STEP));
            end
            push_event(1'b0, EV_SYN, CODE_SYNC, 32'd0);
            touching = 1'b1;
         end else if (t == EV_REL && c == CODE_HSCROLL) begin
            n = pending_events.size();
         end else if (t == EV_REL && (c == CODE_VSCROLL || c == CODE_VSCROLL_FINE)) begin
            gain_ext = {{24{vert_gain[7]}}, vert_gain};
            prod     = v * gain_ext;
            push_event(1'b1, t, c, prod);
         end else begin
            push_event(1'b1, t, c, v);
         end
         if (pending_events.size() > n) begin
            pending_events[pending_events.size() - 1].last = 1'b1;
         end
      endfunction

      task report(string what);
         $display("ERROR: %s", what);
         mismatches++;
      endtask

      task check_word(logic dest, logic [4:0] t, logic [9:0] c, logic [31:0] v, logic last);
         emitted_event_type want;
         if (pending_events.size() == 0) begin
            report($sformatf("unexpected word dest=%0d type=%0d code=%0d value=%h last=%0d",
                             dest, t, c, v, last));
            return;
         end
         want = pending_events.pop_front();
         if (dest !== want.dest || t !== want.ev_type || c !== want.ev_code ||
             v !== want.value || last !== want.last) begin
            report($sformatf("word dest=%0d type=%0d code=%0d value=%h last=%0d, wanted %0d %0d %0d %h %0d",
                             dest, t, c, v, last, want.dest, want.ev_type, want.ev_code,
                             want.value, want.last));
         end
      endtask

   endclass

endpackage

### bench/tb_wheel_to_swipe_translator_top.sv
// Testbench of the wheel to swipe translator: directed and random event words checked against a predictor.
`timescale 1ns / 1ps

module tb_wheel_to_swipe_translator_top;

   import wst_pkg::*;
   import swipe_scoreboard_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [4:0]  req_ev_type;
   logic [9:0]  req_ev_code;
   logic [31:0] req_ev_value;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_dest;
   logic [4:0]  rsp_out_type;
   logic [9:0]  rsp_out_code;
   logic [31:0] rsp_out_value;
   logic        rsp_last;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;

   swipe_scoreboard sb = new();

   wheel_to_swipe_translator_top u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("wheel_to_swipe_translator_top: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word(rsp_dest, rsp_out_type, rsp_out_code, rsp_out_value, rsp_last);
      end
   end

   task automatic send_word(logic op, logic [4:0] t, logic [9:0] c, logic [31:0] v);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_ev_type  <= t;
      req_ev_code  <= c;
      req_ev_value <= v;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, t, c, v);
   endtask

   task automatic settle(int extra);
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock) csr_write_enable <= 1'b0;
   endtask

   task automatic apply_settings(logic [15:0] timeout, logic [7:0] vgain, logic [7:0] pgain);
      write_reg(CSR_IDLE_TIMEOUT, timeout);
      write_reg(CSR_VERTICAL_GAIN, {8'h00, vgain});
      write_reg(CSR_PIXEL_GAIN, {8'h00, pgain});
   endtask

   function automatic logic [31:0] scroll_amount();
      if ($urandom_range(9) == 0) begin
         return $urandom;
      end
      return 32'($urandom_range(40)) - 32'd20;
   endfunction

   task automatic random_item();
      int r;
      int burst;
      r = $urandom_range(99);
      if (r < 35) begin
         send_word(1'b0, EV_REL, CODE_HSCROLL_FINE, scroll_amount());
      end else if (r < 50) begin
         send_word(1'b1, 5'($urandom), 10'($urandom), $urandom);
      end else if (r < 55) begin
         burst = (sb.idle_limit == 0) ? 1 : (sb.idle_limit > 6 ? 6 : int'(sb.idle_limit));
         repeat (burst) send_word(1'b1, 5'($urandom), 10'($urandom), $urandom);
      end else if (r < 65) begin
         send_word(1'b0, EV_REL, $urandom_range(1) ? CODE_VSCROLL : CODE_VSCROLL_FINE,
                   $urandom_range(1) ? $urandom : scroll_amount());
      end else if (r < 70) begin
         send_word(1'b0, EV_REL, CODE_HSCROLL, $urandom);
      end else begin
         send_word(1'b0, 5'($urandom), 10'($urandom), $urandom);
      end
   endtask

   function automatic logic [7:0] nonzero_gain();
      logic [7:0] g;
      g = 8'($urandom_range(255));
      return (g == 8'd0) ? 8'd1 : g;
   endfunction

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = 1'b0;
      req_ev_type      = '0;
      req_ev_code      = '0;
      req_ev_value     = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Register defaults after reset, pass-through, dropping and clamping at both ends.
      send_word(1'b0, 5'd31, 10'd1023, 32'h7FFF_FFFF);
      send_word(1'b0, EV_SYN, CODE_SYNC, 32'h8000_0000);
      send_word(1'b0, EV_REL, CODE_VSCROLL, 32'd5);
      send_word(1'b0, EV_REL, CODE_VSCROLL_FINE, 32'hFFFF_FFFF);
      send_word(1'b0, EV_REL, CODE_HSCROLL, 32'd3);
      send_word(1'b1, 5'd31, 10'd1023, 32'hFFFF_FFFF);
      send_word(1'b0, EV_REL, CODE_HSCROLL_FINE, 32'd10);
      send_word(1'b0, EV_REL, CODE_HSCROLL_FINE, 32'h8000_0000);
      send_word(1'b0, EV_REL, CODE_HSCROLL_FINE, 32'h7FFF_FFFF);
      send_word(1'b1, 5'd0, 10'd0, 32'd0);
      send_word(1'b0, EV_REL, 10'd0, 32'd7);
      send_word(1'b0, EV_ABS, ABS_MT_POS_X, 32'd123);
      settle(DRAIN_CYCLES);

      // A zero timeout lifts on the first tick, and zero gains give zero products.
      apply_settings(16'd0, 8'd0, 8'd0);
      send_word(1'b0, EV_REL, CODE_VSCROLL, 32'h1234_5678);
      send_word(1'b0, EV_REL, CODE_HSCROLL_FINE, 32'h0000_0040);
      send_word(1'b1, 5'd0, 10'd0, 32'd0);
      send_word(1'b1, 5'd0, 10'd0, 32'd0);
      send_word(1'b0, EV_REL, CODE_HSCROLL_FINE, 32'd1);
      send_word(1'b1, 5'd0, 10'd0, 32'd0);
      settle(DRAIN_CYCLES);

      apply_settings(16'd1, 8'sd127, 8'h80);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests++;
      repeat (12) send_word(1'b0, EV_REL, CODE_HSCROLL_FINE, scroll_amount());
      repeat (16) random_item();
      settle(DRAIN_CYCLES);

      apply_settings(16'hFFFF, 8'h80, 8'sd127);
      send_idle_pct = 52;
      stall_pct     = 0;
      repeat (20) random_item();
      settle(DRAIN_CYCLES);

      apply_settings(16'($urandom_range(12, 2)), nonzero_gain(), nonzero_gain());
      send_idle_pct = 0;
      stall_pct     = 52;
      repeat (12) random_item();
      settle(0);
      repeat (12) random_item();
      settle(DRAIN_CYCLES);

      apply_settings(16'd5, 8'hFF, 8'd1);
      send_idle_pct = 11;
      stall_pct     = 11;
      repeat (20) random_item();
      settle(DRAIN_CYCLES);

      if (sb.mismatches == 0) begin
         $display("wheel_to_swipe_translator_top: match");
      end else begin
         $display("wheel_to_swipe_translator_top: mismatch");
      end
      $finish;
   end

endmodule
